// ----- hdl/skdmt_pkg.sv -----
// Shared types and constants for the string-keyed direct-mapped table.
package skdmt_pkg;

  localparam int HASH_W      = 32;
  localparam int CHAR_W      = 8;
  localparam int VALUE_W     = 16;
  localparam int RESULT_W    = 17;
  localparam int CFG_W       = 9;
  localparam int COUNT_W     = 9;
  localparam int STEP_BITS   = 4;
  localparam int DIV_STEPS   = HASH_W / STEP_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  localparam logic [HASH_W-1:0]   HASH_BASE    = 32'd7;
  localparam logic [HASH_W-1:0]   HASH_INIT    = 32'd0;
  localparam logic [HASH_W-1:0]   POWER_INIT   = 32'd1;
  localparam logic [CFG_W-1:0]    SIZE_RESET   = 9'd256;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 9'd511;
  localparam logic [RESULT_W-1:0] EMPTY_RESULT = 17'h1FFFF;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_STORE  = 1'b1;

  // One finished key handed from the hash front end to the table back end.
  typedef struct packed {
    logic                mode;
    logic [HASH_W-1:0]   hash;
    logic [VALUE_W-1:0]  value;
  } job_t;

  // Back end status seen by the front end.
  typedef struct packed {
    logic clearing;
    logic job_full;
  } back_status_t;

endpackage

// ----- hdl/skdmt_front.sv -----
// Front end: accepts key characters and accumulates the polynomial hash.
module skdmt_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_mode,
  input  logic signed [skdmt_pkg::CHAR_W-1:0] in_key_char,
  input  logic                              in_last_char,
  input  logic [skdmt_pkg::VALUE_W-1:0]     in_reg_value,
  input  skdmt_pkg::back_status_t           status,
  output logic                              job_push,
  output skdmt_pkg::job_t                   job
);

  logic [skdmt_pkg::HASH_W-1:0] hash_r, hash_nxt;
  logic [skdmt_pkg::HASH_W-1:0] pow_r, pow_nxt;
  logic [skdmt_pkg::HASH_W-1:0] char_ext;
  logic [skdmt_pkg::HASH_W-1:0] sum;
  logic                         accept;

  assign in_full  = status.clearing | status.job_full;
  assign accept   = in_push & ~in_full;
  assign char_ext = {{(skdmt_pkg::HASH_W - skdmt_pkg::CHAR_W){in_key_char[skdmt_pkg::CHAR_W-1]}},
                     in_key_char};
  // low 32 bits of the product wrap the same for signed and unsigned
  assign sum      = hash_r + char_ext * pow_r;

  always_comb begin
    hash_nxt = hash_r;
    pow_nxt  = pow_r;
    if (accept) begin
      if (in_last_char) begin
        hash_nxt = skdmt_pkg::HASH_INIT;
        pow_nxt  = skdmt_pkg::POWER_INIT;
      end else begin
        hash_nxt = sum;
        pow_nxt  = (pow_r << 3) - pow_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= skdmt_pkg::HASH_INIT;
      pow_r  <= skdmt_pkg::POWER_INIT;
    end else begin
      hash_r <= hash_nxt;
      pow_r  <= pow_nxt;
    end
  end

  assign job_push  = accept & in_last_char;
  assign job.mode  = in_mode;
  assign job.hash  = sum;
  assign job.value = in_reg_value;

endmodule

// ----- hdl/skdmt_fifo.sv -----
// Short job queue between the hash front end and the table back end.
module skdmt_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  skdmt_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output skdmt_pkg::job_t pop_job
);

  skdmt_pkg::job_t                 entry_r [skdmt_pkg::Q_DEPTH];
  logic [skdmt_pkg::Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [skdmt_pkg::Q_CNT_W-1:0]   cnt_r;
  logic                            do_push, do_pop;

  assign full    = (cnt_r == skdmt_pkg::Q_CNT_W'(skdmt_pkg::Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign pop_job = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= skdmt_pkg::Q_CNT_W'(skdmt_pkg::Q_DEPTH))
    else $error("job queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("job queue empty with pointers apart");

endmodule

// ----- hdl/skdmt_back.sv -----
// Back end: modulo reduction, slot table, fill count and result register.
module skdmt_back #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [skdmt_pkg::CFG_W-1:0]         table_size,
  input  logic                                job_empty,
  input  skdmt_pkg::job_t                     job,
  output logic                                job_pop,
  output logic                                clearing,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [skdmt_pkg::RESULT_W-1:0] out_stored_reg,
  output logic [skdmt_pkg::COUNT_W-1:0]       out_entry_count
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int REM_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (REM_W > skdmt_pkg::CFG_W) ? REM_W : skdmt_pkg::CFG_W;
  localparam int WORD_W = skdmt_pkg::VALUE_W + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EXEC
  } state_t;

  state_t                              state_r;
  logic [IDX_W-1:0]                    clr_idx_r;
  logic [skdmt_pkg::HASH_W-1:0]        div_r;
  logic [REM_W-1:0]                    rem_r;
  logic [skdmt_pkg::DIV_CNT_W-1:0]     step_r;
  logic                                mode_r;
  logic [skdmt_pkg::VALUE_W-1:0]       value_r;
  logic [WORD_W-1:0]                   rd_word_r;
  logic [skdmt_pkg::COUNT_W-1:0]       count_r;
  logic                                out_valid_r;
  logic [skdmt_pkg::RESULT_W-1:0]      out_data_r;
  logic [skdmt_pkg::COUNT_W-1:0]       out_cnt_r;

  // slot word: valid bit on top of the stored value
  logic [WORD_W-1:0]                   mem [TABLE_DEPTH];

  logic [CMP_W-1:0]                    size_ext;
  logic [REM_W-1:0]                    size_eff;
  logic [skdmt_pkg::HASH_W-1:0]        div_nxt;
  logic [REM_W-1:0]                    rem_nxt;
  logic [skdmt_pkg::HASH_W-1:0]        mag;
  logic [IDX_W-1:0]                    slot;
  logic                                out_free;
  logic                                slot_valid;
  logic                                mem_we;
  logic [IDX_W-1:0]                    mem_waddr;
  logic [WORD_W-1:0]                   mem_wdata;
  logic [skdmt_pkg::COUNT_W-1:0]       count_nxt;
  logic [skdmt_pkg::RESULT_W-1:0]      result;

  // size of zero acts as one, sizes past the table saturate
  always_comb begin
    size_ext = CMP_W'(table_size);
    if (size_ext == '0) begin
      size_ext = CMP_W'(1);
    end else if (size_ext > CMP_W'(TABLE_DEPTH)) begin
      size_ext = CMP_W'(TABLE_DEPTH);
    end
    size_eff = size_ext[REM_W-1:0];
  end

  // restoring division, STEP_BITS quotient bits per cycle, remainder only
  always_comb begin
    logic [REM_W:0] t;
    div_nxt = div_r;
    rem_nxt = rem_r;
    for (int i = 0; i < skdmt_pkg::STEP_BITS; i++) begin
      t = {rem_nxt, div_nxt[skdmt_pkg::HASH_W-1]};
      if (t >= {1'b0, size_eff}) begin
        t = t - {1'b0, size_eff};
      end
      rem_nxt = t[REM_W-1:0];
      div_nxt = {div_nxt[skdmt_pkg::HASH_W-2:0], 1'b0};
    end
  end

  // most negative hash negates to itself, read as unsigned 2^31
  assign mag  = job.hash[skdmt_pkg::HASH_W-1] ? (skdmt_pkg::HASH_W'(0) - job.hash) : job.hash;
  assign slot = rem_r[IDX_W-1:0];

  assign out_free   = ~out_valid_r | out_pop;
  assign slot_valid = rd_word_r[WORD_W-1];
  assign job_pop    = (state_r == ST_IDLE) & ~job_empty;
  assign clearing   = (state_r == ST_CLEAR);

  always_comb begin
    count_nxt = count_r;
    result    = skdmt_pkg::EMPTY_RESULT;
    if (mode_r == skdmt_pkg::MODE_STORE) begin
      result = {1'b0, value_r};
      if (!slot_valid && count_r != skdmt_pkg::COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
    end else if (slot_valid) begin
      result = {1'b0, rd_word_r[skdmt_pkg::VALUE_W-1:0]};
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = {1'b1, value_r};
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else if (state_r == ST_EXEC && out_free && mode_r == skdmt_pkg::MODE_STORE) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == ST_READ) begin
      rd_word_r <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == IDX_W'(TABLE_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (!job_empty) begin
            div_r   <= mag;
            rem_r   <= '0;
            mode_r  <= job.mode;
            value_r <= job.value;
            step_r  <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_r  <= div_nxt;
          rem_r  <= rem_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == skdmt_pkg::DIV_CNT_W'(skdmt_pkg::DIV_STEPS - 1)) begin
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          if (out_free) begin
            count_r     <= count_nxt;
            out_valid_r <= 1'b1;
            out_data_r  <= result;
            out_cnt_r   <= count_nxt;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_empty       = ~out_valid_r;
  assign out_stored_reg  = out_data_r;
  assign out_entry_count = out_cnt_r;

  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> count_r >= $past(count_r))
    else $error("fill count went down");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!out_valid_r && !job_pop))
    else $error("activity during clearing pass");

  a_store_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && out_free && mode_r == skdmt_pkg::MODE_STORE)
    |=> (out_valid_r && out_data_r == {1'b0, $past(value_r)}))
    else $error("store result differs from stored word");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (rem_r < size_eff))
    else $error("slot index past table size");

endmodule

// ----- hdl/string_keyed_direct_mapped_table_top.sv -----
// Top level of the string-keyed direct-mapped table.
//
//  channel  direction  handshake            payload
//  in_      input      in_push / in_full    in_mode, in_key_char, in_last_char, in_reg_value
//  out_     output     out_empty / out_pop  out_stored_reg, out_entry_count
//  cfg_     input      cfg_valid/cfg_ready  cfg_data (table_size)
//
// Key characters are taken one per cycle while in_full is low; the hash multiply-add runs in
// the front end. A finished key waits in a two-word queue; the back end then loads it, runs the
// 4-bit-per-cycle modulo unit for DIV_STEPS (8) steps, then reads and updates the slot, and takes
// the next key only when that one is through.
// After reset a clearing pass over all TABLE_DEPTH slots holds in_full high.
// A result waiting in the output register stalls the back end; in_full rises once the queue fills.
module string_keyed_direct_mapped_table_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic                                  in_mode,
  input  logic signed [skdmt_pkg::CHAR_W-1:0]   in_key_char,
  input  logic                                  in_last_char,
  input  logic [skdmt_pkg::VALUE_W-1:0]         in_reg_value,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic signed [skdmt_pkg::RESULT_W-1:0] out_stored_reg,
  output logic [skdmt_pkg::COUNT_W-1:0]         out_entry_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [skdmt_pkg::CFG_W-1:0]           cfg_data
);

  logic [skdmt_pkg::CFG_W-1:0] size_r;
  skdmt_pkg::back_status_t     status;
  skdmt_pkg::job_t             push_job, pop_job;
  logic                        job_push, job_pop, job_full, job_empty, clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= skdmt_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_r <= cfg_data;
    end
  end

  assign status.clearing = clearing;
  assign status.job_full = job_full;

  skdmt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_mode      (in_mode),
    .in_key_char  (in_key_char),
    .in_last_char (in_last_char),
    .in_reg_value (in_reg_value),
    .status       (status),
    .job_push     (job_push),
    .job          (push_job)
  );

  skdmt_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .full     (job_full),
    .pop      (job_pop),
    .empty    (job_empty),
    .pop_job  (pop_job)
  );

  skdmt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .table_size      (size_r),
    .job_empty       (job_empty),
    .job             (pop_job),
    .job_pop         (job_pop),
    .clearing        (clearing),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_stored_reg  (out_stored_reg),
    .out_entry_count (out_entry_count)
  );

endmodule

// ----- tb/string_keyed_direct_mapped_table_top_tb.sv -----
// Self-checking testbench for the string-keyed direct-mapped table top level.
module string_keyed_direct_mapped_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS         = 256;
  localparam int SLOT_W        = $clog2(SLOTS);
  localparam int ITEM_GOAL     = 1350;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int POOL_SIZE     = 32;
  localparam int KEY_MAX       = 24;
  localparam int IDLE_PCT      = 26;
  localparam int DIR_ROWS      = 24;
  localparam int PHASES        = 12;

  typedef enum logic {ROW_CHAR, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic signed [skdmt_pkg::RESULT_W-1:0] stored_reg;
    logic [skdmt_pkg::COUNT_W-1:0]         entry_count;
  } table_result_t;

  typedef struct packed {
    row_kind_t                           kind;
    logic                                mode;
    logic signed [skdmt_pkg::CHAR_W-1:0] key_char;
    logic                                key_last;
    logic [skdmt_pkg::VALUE_W-1:0]       reg_value;
    logic [skdmt_pkg::CFG_W-1:0]         size;
    logic                                typed_in;
    table_result_t                       result;
  } dir_row_t;

  localparam table_result_t NO_RESULT = '0;
  localparam logic [skdmt_pkg::RESULT_W-1:0] EMPTY_WORD = skdmt_pkg::EMPTY_RESULT;

  logic                                  clk = 1'b0;
  logic                                  rst_n = 1'b0;
  logic                                  in_push = 1'b0;
  logic                                  in_full;
  logic                                  in_mode = skdmt_pkg::MODE_LOOKUP;
  logic signed [skdmt_pkg::CHAR_W-1:0]   in_key_char = '0;
  logic                                  in_last_char = 1'b0;
  logic [skdmt_pkg::VALUE_W-1:0]         in_reg_value = '0;
  logic                                  out_empty;
  logic                                  out_pop = 1'b0;
  logic signed [skdmt_pkg::RESULT_W-1:0] out_stored_reg;
  logic [skdmt_pkg::COUNT_W-1:0]         out_entry_count;
  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic [skdmt_pkg::CFG_W-1:0]           cfg_data = '0;

  // shadow of the table
  logic [skdmt_pkg::HASH_W-1:0]  run_hash;
  logic [skdmt_pkg::HASH_W-1:0]  run_power;
  logic [skdmt_pkg::CFG_W-1:0]   model_size;
  logic                          slot_full [SLOTS];
  logic [skdmt_pkg::VALUE_W-1:0] slot_data [SLOTS];
  logic [skdmt_pkg::COUNT_W-1:0] fill_count;

  table_result_t pending_results [$];
  dir_row_t      directed_rows [DIR_ROWS];
  int            failures = 0;
  bit            gapless = 1'b0;
  int            idle_cycles;

  string_keyed_direct_mapped_table_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_mode         (in_mode),
    .in_key_char     (in_key_char),
    .in_last_char    (in_last_char),
    .in_reg_value    (in_reg_value),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_stored_reg  (out_stored_reg),
    .out_entry_count (out_entry_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Folds one character into the running hash; on the final one, looks up or
  // stores the slot and returns 1 with the result it produces.
  function automatic bit hash_char(input logic mode,
                                   input logic signed [skdmt_pkg::CHAR_W-1:0] ch,
                                   input logic key_last,
                                   input logic [skdmt_pkg::VALUE_W-1:0] value,
                                   output table_result_t res);
    logic [skdmt_pkg::HASH_W-1:0] mag;
    logic [skdmt_pkg::HASH_W-1:0] modulus;
    logic [skdmt_pkg::HASH_W-1:0] slot;
    logic [SLOT_W-1:0]            slot_idx;
    res = NO_RESULT;
    run_hash  = run_hash
              + {{(skdmt_pkg::HASH_W-skdmt_pkg::CHAR_W){ch[skdmt_pkg::CHAR_W-1]}}, ch}
              * run_power;
    run_power = run_power * skdmt_pkg::HASH_BASE;
    if (!key_last) return 1'b0;
    // most negative hash stays 2^31 as an unsigned magnitude
    mag = run_hash[skdmt_pkg::HASH_W-1] ? -run_hash : run_hash;
    if (model_size == '0) modulus = skdmt_pkg::HASH_W'(1);
    else if (model_size > skdmt_pkg::CFG_W'(SLOTS)) modulus = skdmt_pkg::HASH_W'(SLOTS);
    else modulus = skdmt_pkg::HASH_W'(model_size);
    slot = mag % modulus;
    slot_idx = slot[SLOT_W-1:0];
    run_hash  = skdmt_pkg::HASH_INIT;
    run_power = skdmt_pkg::POWER_INIT;
    if (mode == skdmt_pkg::MODE_STORE) begin
      if (!slot_full[slot_idx]) begin
        slot_full[slot_idx] = 1'b1;
        if (fill_count != skdmt_pkg::COUNT_MAX) fill_count++;
      end
      slot_data[slot_idx] = value;
      res.stored_reg = {1'b0, value};
    end else if (slot_full[slot_idx]) begin
      res.stored_reg = {1'b0, slot_data[slot_idx]};
    end else begin
      res.stored_reg = skdmt_pkg::EMPTY_RESULT;
    end
    res.entry_count = fill_count;
    return 1'b1;
  endfunction

  task automatic send_char(input logic mode, input logic signed [skdmt_pkg::CHAR_W-1:0] ch,
                           input logic key_last, input logic [skdmt_pkg::VALUE_W-1:0] value,
                           input logic typed_in, input table_result_t typed_result);
    table_result_t predicted;
    if (!gapless) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_push <= 1'b0;
        @(posedge clk);
      end
    end
    in_push      <= 1'b1;
    in_mode      <= mode;
    in_key_char  <= ch;
    in_last_char <= key_last;
    in_reg_value <= value;
    do @(posedge clk); while (in_full);
    if (hash_char(mode, ch, key_last, value, predicted))
      pending_results.push_back(typed_in ? typed_result : predicted);
  endtask

  // table_size changes only with the table drained and the back end quiet
  task automatic write_size(input logic [skdmt_pkg::CFG_W-1:0] size);
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_size = size;
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected word: stored_reg %0d entry_count %0d",
               out_stored_reg, out_entry_count);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_stored_reg !== want.stored_reg) begin
          $error("stored_reg: expected %0d, actual %0d", want.stored_reg, out_stored_reg);
          failures++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, out_entry_count);
          failures++;
        end
      end
    end
    out_pop <= gapless || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("string_keyed_direct_mapped_table_top verification failed");
    $finish;
  end

  initial begin : stimulus
    logic signed [skdmt_pkg::CHAR_W-1:0] pool_chars [POOL_SIZE][KEY_MAX];
    int                                  pool_len [POOL_SIZE];
    logic [skdmt_pkg::CFG_W-1:0]         phase_sizes [PHASES];
    int                                  pool_used;
    int                                  pool_next;
    int                                  idx;
    int                                  len;
    int                                  sent;
    int                                  phase_goal;
    logic                                key_mode;
    logic [skdmt_pkg::VALUE_W-1:0]       key_value;
    logic signed [skdmt_pkg::CHAR_W-1:0] ch;

    run_hash   = skdmt_pkg::HASH_INIT;
    run_power  = skdmt_pkg::POWER_INIT;
    model_size = skdmt_pkg::SIZE_RESET;
    fill_count = '0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_full[s] = 1'b0;
      slot_data[s] = '0;
    end

    directed_rows = '{
      // single-character keys at reset size 256
      '{ROW_CHAR, skdmt_pkg::MODE_LOOKUP, 8'sd0, 1'b1, 16'h0000, 9'd0, 1'b1, '{EMPTY_WORD, 9'd0}},
      '{ROW_CHAR, skdmt_pkg::MODE_STORE, 8'sd0, 1'b1, 16'hFFFF, 9'd0, 1'b1, '{17'sh0FFFF, 9'd1}},
      '{ROW_CHAR, skdmt_pkg::MODE_LOOKUP, 8'sd0, 1'b1, 16'h0000, 9'd0, 1'b1, '{17'sh0FFFF, 9'd1}},
      '{ROW_CHAR, skdmt_pkg::MODE_STORE, -8'sd128, 1'b1, 16'h0000, 9'd0, 1'b1, '{17'sh00000, 9'd2}},
      '{ROW_CHAR, skdmt_pkg::MODE_LOOKUP, 8'sd127, 1'b1, 16'hFFFF, 9'd0, 1'b1, '{EMPTY_WORD, 9'd2}},
      // overwrite of an occupied slot keeps the count
      '{ROW_CHAR, skdmt_pkg::MODE_STORE, -8'sd128, 1'b1, 16'h1234, 9'd0, 1'b1, '{17'sh01234, 9'd2}},
      // key whose hash is exactly 2^31
      '{ROW_CHAR, skdmt_pkg::MODE_STORE,  8'sd2,    1'b0, 16'hFFFF, 9'd0, 1'b0, NO_RESULT},
      '{ROW_CHAR, skdmt_pkg::MODE_LOOKUP, -8'sd1,   1'b0, 16'h0000, 9'd0, 1'b0, NO_RESULT},
      '{ROW_CHAR, skdmt_pkg::MODE_STORE,  8'sd2,    1'b0, 16'hFFFF, 9'd0, 1'b0, NO_RESULT},
      '{ROW_CHAR, skdmt_pkg::MODE_LOOKUP, 8'sd1,    1'b0, 16'h0000, 9'd0, 1'b0, NO_RESULT},
      '{ROW_CHAR, skdmt_pkg::MODE_STORE,  8'sd1,    1'b0, 16'hFFFF, 9'd0, 1'b0, NO_RESULT},
      '{ROW_CHAR, skdmt_pkg::MODE_LOOKUP, 8'sd2,    1'b0, 16'h0000, 9'd0, 1'b0, NO_RESULT},
      '{ROW_CHAR, skdmt_pkg::MODE_STORE,  -8'sd3,   1'b0, 16'hFFFF, 9'd0, 1'b0, NO_RESULT},
      '{ROW_CHAR, skdmt_pkg::MODE_LOOKUP, -8'sd3,   1'b0, 16'h0000, 9'd0, 1'b0, NO_RESULT},
      '{ROW_CHAR, skdmt_pkg::MODE_STORE,  8'sd2,    1'b0, 16'hFFFF, 9'd0, 1'b0, NO_RESULT},
      '{ROW_CHAR, skdmt_pkg::MODE_LOOKUP, -8'sd3,   1'b0, 16'h0000, 9'd0, 1'b0, NO_RESULT},
      '{ROW_CHAR, skdmt_pkg::MODE_STORE,  8'sd1,    1'b0, 16'hFFFF, 9'd0, 1'b0, NO_RESULT},
      '{ROW_CHAR, skdmt_pkg::MODE_STORE,  8'sd1,    1'b1, 16'hA5A5, 9'd0, 1'b0, NO_RESULT},
      // two-character key
      '{ROW_CHAR, skdmt_pkg::MODE_LOOKUP, 8'sd97,   1'b0, 16'h0000, 9'd0, 1'b0, NO_RESULT},
      '{ROW_CHAR, skdmt_pkg::MODE_STORE,  8'sd98,   1'b1, 16'h00FF, 9'd0, 1'b0, NO_RESULT},
      // size zero maps everything to slot 0, oversize saturates
      '{ROW_CFG,  skdmt_pkg::MODE_LOOKUP, 8'sd0,    1'b0, 16'h0000, 9'd0, 1'b0, NO_RESULT},
      '{ROW_CHAR, skdmt_pkg::MODE_LOOKUP, 8'sd55,   1'b1, 16'h0000, 9'd0, 1'b0, NO_RESULT},
      '{ROW_CFG,  skdmt_pkg::MODE_LOOKUP, 8'sd0,    1'b0, 16'h0000, 9'd511, 1'b0, NO_RESULT},
      '{ROW_CHAR, skdmt_pkg::MODE_LOOKUP, -8'sd128, 1'b1, 16'h0000, 9'd0, 1'b0, NO_RESULT}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG)
        write_size(directed_rows[r].size);
      else
        send_char(directed_rows[r].mode, directed_rows[r].key_char, directed_rows[r].key_last,
                  directed_rows[r].reg_value, directed_rows[r].typed_in,
                  directed_rows[r].result);
    end

    phase_sizes = '{9'd1, 9'd256, 9'd2, 9'd511, 9'd0, 9'd255, 9'd3,
                    skdmt_pkg::CFG_W'($urandom_range(300, 4)), 9'd257, 9'd256,
                    skdmt_pkg::CFG_W'($urandom_range(511, 1)), 9'd16};
    sent      = 0;
    pool_used = 0;
    pool_next = 0;
    foreach (phase_sizes[p]) begin
      write_size(phase_sizes[p]);
      gapless    = (p == 3);
      phase_goal = sent + ITEM_GOAL / PHASES;
      while (sent < phase_goal) begin
        if (pool_used != 0 && $urandom_range(99) < 35) begin
          // revisit a recent key, mostly to read back what was stored
          idx      = int'($urandom_range(pool_used - 1));
          key_mode = ($urandom_range(99) < 75) ? skdmt_pkg::MODE_LOOKUP : skdmt_pkg::MODE_STORE;
        end else begin
          idx       = pool_next;
          pool_next = (pool_next + 1) % POOL_SIZE;
          if (pool_used < POOL_SIZE) pool_used++;
          case ($urandom_range(19))
            0:       len = int'($urandom_range(KEY_MAX, 13));
            1, 2, 3: len = int'($urandom_range(12, 5));
            default: len = int'($urandom_range(4, 1));
          endcase
          pool_len[idx] = len;
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0)
              pool_chars[idx][k] = $urandom_range(1) ? 8'sh80 : 8'sh7F;
            else
              pool_chars[idx][k] = skdmt_pkg::CHAR_W'($urandom);
          end
          key_mode = 1'($urandom_range(1));
        end
        if ($urandom_range(15) == 0)
          key_value = $urandom_range(1) ? '1 : '0;
        else
          key_value = skdmt_pkg::VALUE_W'($urandom);
        for (int k = 0; k < pool_len[idx]; k++) begin
          ch = pool_chars[idx][k];
          if (k == pool_len[idx] - 1)
            send_char(key_mode, ch, 1'b1, key_value, 1'b0, NO_RESULT);
          else  // mode and value of inner characters are don't-care
            send_char(1'($urandom_range(1)), ch, 1'b0, skdmt_pkg::VALUE_W'($urandom), 1'b0,
                      NO_RESULT);
          sent++;
        end
      end
    end

    gapless = 1'b0;
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("string_keyed_direct_mapped_table_top verification clean");
    else
      $display("string_keyed_direct_mapped_table_top verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/skdmt_pkg.sv
hdl/skdmt_front.sv
hdl/skdmt_fifo.sv
hdl/skdmt_back.sv
hdl/string_keyed_direct_mapped_table_top.sv
tb/string_keyed_direct_mapped_table_top_tb.sv
